// File: src/assert_macros.svh
// Assertion macros used by the checker file dpa_checker.sv.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dpa_pkg.sv
// Shared types and constants of the dynamic partition allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package dpa_pkg;

  localparam int DEF_MAX_PARTITIONS = 64;
  localparam int DEF_ADDR_BITS      = 16;
  localparam int MEM_SIZE_RESET     = 4096;
  localparam int REQ_W              = 17;
  localparam int BASE_W             = 16;
  localparam int CFG_W              = 17;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;

  localparam logic REG_MEMORY_SIZE = 1'b0;
  localparam logic REG_FIT_MODE    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOBASE = 2'd3
  } status_t;

  typedef struct packed {
    logic    init;
    logic    load;
    logic    scan;
    logic    shift_start;
    logic    shift;
    logic    alloc_exact;
    logic    split_hi;
    logic    split_lo;
    logic    free_fin;
    logic    comp_fin;
    logic    respond;
    status_t code;
    logic    grant;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic nofit;
    logic exact;
    logic full;
    logic hit;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/dpa_ctrl.sv
// Command sequencer of the dynamic partition allocator.
// Depends on dpa_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none
module dpa_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire  [1:0]        in_command,
  input  wire               msize_wr,
  input  dpa_pkg::dp_status_t st,
  output dpa_pkg::ctrl_cmd_t  cmd,
  output logic              busy
);
  import dpa_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_FIN, S_SHIFT, S_SPLIT_HI, S_SPLIT_LO, S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic       busy_r;
  logic [1:0] op_r, op_nxt;
  status_t    code_r, code_nxt;
  logic       grant_r, grant_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    code_nxt  = code_r;
    grant_nxt = grant_r;
    cmd       = '0;
    cmd.code  = code_r;
    cmd.grant = grant_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          op_nxt    = in_command;
          code_nxt  = ST_OK;
          grant_nxt = 1'b0;
          if (in_command == CMD_ALLOC || in_command == CMD_FREE ||
              in_command == CMD_COMPACT) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (msize_wr) begin
          state_nxt = S_INIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_RESP;
        priority if (op_r == CMD_ALLOC) begin
          priority if (st.nofit) begin
            code_nxt = ST_NOFIT;
          end else if (st.exact) begin
            cmd.alloc_exact = 1'b1;
            grant_nxt       = 1'b1;
          end else if (st.full) begin
            code_nxt = ST_FULL;
          end else begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end
        end else if (op_r == CMD_FREE) begin
          cmd.free_fin = 1'b1;
          code_nxt     = st.hit ? ST_OK : ST_NOBASE;
        end else begin
          cmd.comp_fin = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) begin
          state_nxt = S_SPLIT_HI;
        end
      end
      S_SPLIT_HI: begin
        cmd.split_hi = 1'b1;
        state_nxt    = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        cmd.split_lo = 1'b1;
        grant_nxt    = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
      op_r    <= CMD_ALLOC;
      code_r  <= ST_OK;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      op_r    <= op_nxt;
      code_r  <= code_nxt;
      grant_r <= grant_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// File: src/dpa_datapath.sv
// Partition table memory, scan accumulators and result registers.
// Depends on dpa_pkg; commanded by dpa_ctrl.
`default_nettype none
module dpa_datapath #(
  parameter int MAX_PARTITIONS = dpa_pkg::DEF_MAX_PARTITIONS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  dpa_pkg::ctrl_cmd_t          cmd,
  output dpa_pkg::dp_status_t         st,
  input  wire  [1:0]                  in_command,
  input  wire  [dpa_pkg::REQ_W-1:0]   in_request_size,
  input  wire  [dpa_pkg::BASE_W-1:0]  in_free_base,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire  [dpa_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [dpa_pkg::BASE_W-1:0]  out_granted_base
);
  import dpa_pkg::*;

  localparam int ADDR_BITS = DEF_ADDR_BITS;
  localparam int SW  = ADDR_BITS + 1;
  localparam int CW  = (SW > REQ_W) ? SW : REQ_W;
  localparam int BW  = (SW > BASE_W) ? SW : BASE_W;
  localparam int IW  = $clog2(MAX_PARTITIONS);
  localparam int CNW = $clog2(MAX_PARTITIONS + 1);
  localparam longint LIM     = longint'(1) << ADDR_BITS;
  localparam longint RST_MSZ = (MEM_SIZE_RESET > LIM) ? LIM : MEM_SIZE_RESET;
  localparam logic [CW-1:0]  LIM_CW  = CW'(LIM);
  localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_PARTITIONS);

  typedef struct packed {
    logic          free;
    logic [SW-1:0] size;
  } entry_t;

  entry_t mem [MAX_PARTITIONS];

  logic           we, ren;
  logic [IW-1:0]  waddr, raddr;
  entry_t         wdata;
  entry_t         rdata_r;
  logic           rv_r;
  logic [IW-1:0]  rd_addr_r;

  logic [CNW-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt, wptr_r, wptr_nxt;
  logic [SW-1:0]  base_r, base_nxt, next_r, next_nxt;
  logic           found_r, found_nxt, hit_r, hit_nxt;
  logic [IW-1:0]  pick_r, pick_nxt;
  logic [SW-1:0]  pick_size_r, pick_size_nxt, pick_base_r, pick_base_nxt;
  entry_t         pend_r, pend_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [CW-1:0]  req_r, req_nxt;
  logic [BW-1:0]  fbase_r, fbase_nxt;
  logic [SW-1:0]  msize_r, msize_nxt;
  logic           fit_r, fit_nxt;
  logic           ov_r, ov_nxt;
  status_t        ost_r, ost_nxt;
  logic [BASE_W-1:0] ogb_r, ogb_nxt;

  always_comb begin
    logic [CW-1:0] v;
    logic          is_hit, eff_free, fits;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    wptr_nxt      = wptr_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    pick_nxt      = pick_r;
    pick_size_nxt = pick_size_r;
    pick_base_nxt = pick_base_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    fbase_nxt     = fbase_r;
    msize_nxt     = msize_r;
    fit_nxt       = fit_r;
    ov_nxt        = 1'b0;
    ost_nxt       = ost_r;
    ogb_nxt       = ogb_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    ren           = 1'b0;
    raddr         = ptr_r[IW-1:0];
    v             = CW'(cfg_wdata);
    is_hit        = (BW'(base_r) == fbase_r);
    eff_free      = rdata_r.free | is_hit;
    fits          = rdata_r.free && (CW'(rdata_r.size) >= req_r);

    if (cfg_we) begin
      if (cfg_index == REG_MEMORY_SIZE) begin
        if (v == '0) begin
          v = CW'(1);
        end
        if (v > LIM_CW) begin
          v = LIM_CW;
        end
        msize_nxt = SW'(v);
      end else begin
        fit_nxt = cfg_wdata[0];
      end
    end

    if (cmd.init) begin
      we      = 1'b1;
      waddr   = '0;
      wdata   = '{free: 1'b1, size: msize_r};
      cnt_nxt = CNW'(1);
    end

    if (cmd.load) begin
      ptr_nxt    = '0;
      wptr_nxt   = '0;
      base_nxt   = '0;
      next_nxt   = '0;
      found_nxt  = 1'b0;
      hit_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
      op_nxt     = in_command;
      req_nxt    = CW'(in_request_size);
      fbase_nxt  = BW'(in_free_base);
    end

    if (cmd.scan) begin
      if (ptr_r < cnt_r) begin
        ren     = 1'b1;
        ptr_nxt = ptr_r + CNW'(1);
      end
      if (rv_r) begin
        base_nxt = base_r + rdata_r.size;
        if (op_r == CMD_ALLOC) begin
          if (fits && (!found_r || (fit_r && rdata_r.size < pick_size_r))) begin
            found_nxt     = 1'b1;
            pick_nxt      = rd_addr_r;
            pick_size_nxt = rdata_r.size;
            pick_base_nxt = base_r;
          end
        end else if (op_r == CMD_FREE) begin
          hit_nxt = hit_r | is_hit;
          if (pend_v_r && pend_r.free && eff_free) begin
            pend_nxt.size = pend_r.size + rdata_r.size;
          end else begin
            if (pend_v_r) begin
              we       = 1'b1;
              waddr    = wptr_r[IW-1:0];
              wdata    = pend_r;
              wptr_nxt = wptr_r + CNW'(1);
            end
            pend_nxt   = '{free: eff_free, size: rdata_r.size};
            pend_v_nxt = 1'b1;
          end
        end else begin
          if (!rdata_r.free) begin
            we       = 1'b1;
            waddr    = wptr_r[IW-1:0];
            wdata    = rdata_r;
            wptr_nxt = wptr_r + CNW'(1);
            next_nxt = next_r + rdata_r.size;
          end
        end
      end
    end

    if (cmd.shift_start) begin
      ptr_nxt = cnt_r - CNW'(1);
    end

    if (cmd.shift) begin
      if (ptr_r > CNW'(pick_r)) begin
        ren     = 1'b1;
        ptr_nxt = ptr_r - CNW'(1);
      end
      if (rv_r) begin
        we    = 1'b1;
        waddr = rd_addr_r + IW'(1);
        wdata = rdata_r;
      end
    end

    if (cmd.alloc_exact) begin
      we    = 1'b1;
      waddr = pick_r;
      wdata = '{free: 1'b0, size: pick_size_r};
    end

    if (cmd.split_hi) begin
      we    = 1'b1;
      waddr = pick_r + IW'(1);
      wdata = '{free: 1'b1, size: pick_size_r - SW'(req_r)};
    end

    if (cmd.split_lo) begin
      we      = 1'b1;
      waddr   = pick_r;
      wdata   = '{free: 1'b0, size: SW'(req_r)};
      cnt_nxt = cnt_r + CNW'(1);
    end

    if (cmd.free_fin) begin
      we      = 1'b1;
      waddr   = wptr_r[IW-1:0];
      wdata   = pend_r;
      cnt_nxt = wptr_r + CNW'(1);
    end

    if (cmd.comp_fin) begin
      if (next_r < msize_r && wptr_r < MAX_CNT) begin
        we      = 1'b1;
        waddr   = wptr_r[IW-1:0];
        wdata   = '{free: 1'b1, size: msize_r - next_r};
        cnt_nxt = wptr_r + CNW'(1);
      end else begin
        cnt_nxt = wptr_r;
      end
    end

    if (cmd.respond) begin
      ov_nxt  = 1'b1;
      ost_nxt = cmd.code;
      ogb_nxt = cmd.grant ? BASE_W'(pick_base_r) : '0;
    end
  end

  always_comb begin
    st.scan_done  = !(ptr_r < cnt_r) && !rv_r;
    st.shift_done = !(ptr_r > CNW'(pick_r)) && !rv_r;
    st.nofit      = !found_r || (req_r == '0);
    st.exact      = (CW'(pick_size_r) == req_r);
    st.full       = (cnt_r == MAX_CNT);
    st.hit        = hit_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_r <= mem[raddr];
    end
    rd_addr_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r     <= 1'b0;
      cnt_r    <= CNW'(1);
      msize_r  <= SW'(RST_MSZ);
      fit_r    <= 1'b0;
      ov_r     <= 1'b0;
      ost_r    <= ST_OK;
      ogb_r    <= '0;
      ptr_r    <= '0;
      wptr_r   <= '0;
      found_r  <= 1'b0;
      hit_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      rv_r     <= ren;
      cnt_r    <= cnt_nxt;
      msize_r  <= msize_nxt;
      fit_r    <= fit_nxt;
      ov_r     <= ov_nxt;
      ost_r    <= ost_nxt;
      ogb_r    <= ogb_nxt;
      ptr_r    <= ptr_nxt;
      wptr_r   <= wptr_nxt;
      found_r  <= found_nxt;
      hit_r    <= hit_nxt;
      pend_v_r <= pend_v_nxt;
    end
    base_r      <= base_nxt;
    next_r      <= next_nxt;
    pick_r      <= pick_nxt;
    pick_size_r <= pick_size_nxt;
    pick_base_r <= pick_base_nxt;
    pend_r      <= pend_nxt;
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    fbase_r     <= fbase_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_granted_base = ogb_r;

endmodule
`default_nettype wire

// File: src/dynamic_partition_allocator.sv
// Top level of the dynamic partition allocator.
// Depends on dpa_pkg, dpa_ctrl and dpa_datapath.
//
// Usage:
//   Command channel: a command is taken at a rising edge with start high and
//   busy low; in_command selects allocate, free or compact.
//   Result channel: out_valid strobes for one cycle with out_status and
//   out_granted_base; the receiver takes every beat and cannot stall.
//   Config channel: cfg_valid/cfg_ready (always ready) with cfg_index and
//   cfg_wdata; write only while idle. A memory_size write rebuilds the table.
// Sequence: free, compact and every allocate scan the partitions in use once;
//   an allocate with split then moves each entry above the chosen one up by
//   one place, last entry first, and writes the two halves of the split.
//   An unknown command skips the scan and only returns a result beat.
//   One table read per cycle goes through the single read port of the
//   partition memory.
//   busy drops in the strobe cycle.
// Reset: busy is high for one cycle while entry 0 of the table is written;
//   so does a memory_size write taken while idle with start low.
`default_nettype none
module dynamic_partition_allocator #(
  parameter int MAX_PARTITIONS = dpa_pkg::DEF_MAX_PARTITIONS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  in_command,
  input  wire  [dpa_pkg::REQ_W-1:0]   in_request_size,
  input  wire  [dpa_pkg::BASE_W-1:0]  in_free_base,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [dpa_pkg::BASE_W-1:0]  out_granted_base,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire                         cfg_index,
  input  wire  [dpa_pkg::CFG_W-1:0]   cfg_wdata
);
  import dpa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       cfg_we;
  logic       msize_wr;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign msize_wr  = cfg_we && (cfg_index == REG_MEMORY_SIZE);

  dpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .msize_wr   (msize_wr),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy)
  );

  dpa_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_command       (in_command),
    .in_request_size  (in_request_size),
    .in_free_base     (in_free_base),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_granted_base (out_granted_base)
  );

endmodule
`default_nettype wire

// File: src/dpa_checker.sv
// Port-level checks of the dynamic partition allocator and their bind.
// Depends on dpa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dpa_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        start,
  input wire                        busy,
  input wire                        out_valid,
  input wire [1:0]                  out_status,
  input wire [dpa_pkg::BASE_W-1:0]  out_granted_base
);
  import dpa_pkg::*;

  `CHK_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted command")
  `CHK_SAME(a_result_after_work, out_valid, $past(busy), "result beat without work")
  `CHK_NEXT(a_single_beat, out_valid, !out_valid, "result beat repeated")
  `CHK_SAME(a_fail_no_base, out_valid && (out_status != ST_OK), out_granted_base == '0,
            "granted base nonzero on failure")

endmodule

bind dynamic_partition_allocator dpa_checker u_dpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_granted_base (out_granted_base)
);
`default_nettype wire

// File: dv/alloc_scoreboard.sv
// Scoreboard class for the dynamic partition allocator testbench.
// Holds a behavioral model of the partition table; depends on dpa_pkg.
`timescale 1ns / 100ps
class alloc_scoreboard;
  localparam int NPART = dpa_pkg::DEF_MAX_PARTITIONS;
  logic [16:0] mem_bytes;
  logic        tight_fit;
  logic [16:0] p_base[NPART];
  logic [16:0] p_size[NPART];
  bit          p_free[NPART];
  int          n_parts;
  dpa_pkg::status_t exp_status[$];
  logic [15:0] exp_base[$];
  int          errors;
  int          checked;

  function new();
    errors = 0;
    checked = 0;
    mem_bytes = 17'(dpa_pkg::MEM_SIZE_RESET);
    tight_fit = 1'b0;
    rebuild();
  endfunction

  function void rebuild();
    for (int i = 0; i < NPART; i++) begin
      p_base[i] = '0;
      p_size[i] = '0;
      p_free[i] = 1'b0;
    end
    p_size[0] = mem_bytes;
    p_free[0] = 1'b1;
    n_parts = 1;
  endfunction

  function void write_reg(logic idx, logic [16:0] val);
    if (idx == dpa_pkg::REG_MEMORY_SIZE) begin
      if (val == 17'd0) val = 17'd1;
      if (val > 17'h10000) val = 17'h10000;
      mem_bytes = val;
      rebuild();
    end else begin
      tight_fit = val[0];
    end
  endfunction

  function void merge_free();
    int w;
    w = 0;
    for (int r = 0; r < n_parts; r++) begin
      if (w > 0 && p_free[w-1] && p_free[r]) begin
        p_size[w-1] += p_size[r];
      end else begin
        p_base[w] = p_base[r];
        p_size[w] = p_size[r];
        p_free[w] = p_free[r];
        w++;
      end
    end
    n_parts = w;
  endfunction

  function void allocate(logic [16:0] req, output dpa_pkg::status_t st,
                         output logic [15:0] gb);
    int  pick;
    bit  found;
    pick = 0;
    found = 0;
    st = dpa_pkg::ST_OK;
    gb = '0;
    if (req == 17'd0) begin
      st = dpa_pkg::ST_NOFIT;
      return;
    end
    for (int i = 0; i < n_parts; i++) begin
      if (!p_free[i] || p_size[i] < req) continue;
      if (!found || (tight_fit && p_size[i] < p_size[pick])) begin
        pick = i;
        found = 1;
        if (!tight_fit) break;
      end
    end
    if (!found) begin
      st = dpa_pkg::ST_NOFIT;
    end else if (p_size[pick] == req) begin
      p_free[pick] = 1'b0;
      gb = p_base[pick][15:0];
    end else if (n_parts >= NPART) begin
      st = dpa_pkg::ST_FULL;
    end else begin
      for (int i = n_parts; i > pick + 1; i--) begin
        p_base[i] = p_base[i-1];
        p_size[i] = p_size[i-1];
        p_free[i] = p_free[i-1];
      end
      p_base[pick+1] = p_base[pick] + req;
      p_size[pick+1] = p_size[pick] - req;
      p_free[pick+1] = 1'b1;
      p_size[pick] = req;
      p_free[pick] = 1'b0;
      n_parts++;
      gb = p_base[pick][15:0];
    end
  endfunction

  function void compact();
    int w;
    logic [16:0] nxt;
    w = 0;
    nxt = '0;
    for (int r = 0; r < n_parts; r++) begin
      if (!p_free[r]) begin
        p_size[w] = p_size[r];
        p_base[w] = nxt;
        p_free[w] = 1'b0;
        nxt += p_size[r];
        w++;
      end
    end
    if (nxt < mem_bytes && w < NPART) begin
      p_base[w] = nxt;
      p_size[w] = mem_bytes - nxt;
      p_free[w] = 1'b1;
      w++;
    end
    n_parts = w;
  endfunction

  function void note_command(logic [1:0] cmd, logic [16:0] req, logic [15:0] fb);
    dpa_pkg::status_t st;
    logic [15:0] gb;
    bit hit;
    st = dpa_pkg::ST_OK;
    gb = '0;
    hit = 0;
    case (cmd)
      dpa_pkg::CMD_ALLOC: allocate(req, st, gb);
      dpa_pkg::CMD_FREE: begin
        for (int i = 0; i < n_parts; i++)
          if (p_base[i] == {1'b0, fb}) begin
            p_free[i] = 1'b1;
            hit = 1;
          end
        if (hit) merge_free();
        else st = dpa_pkg::ST_NOBASE;
      end
      dpa_pkg::CMD_COMPACT: compact();
      default: ;
    endcase
    exp_status.push_back(st);
    exp_base.push_back(gb);
  endfunction

  task check_result(logic [1:0] st, logic [15:0] gb);
    dpa_pkg::status_t es;
    logic [15:0] eb;
    checked++;
    if (exp_status.size() == 0) begin
      report("unexpected result beat");
      return;
    end
    es = exp_status.pop_front();
    eb = exp_base.pop_front();
    if (st !== es) report($sformatf("status %0d, want %0d", st, es));
    if (gb !== eb) report($sformatf("granted_base %0h, want %0h", gb, eb));
  endtask

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function int pending();
    return exp_status.size();
  endfunction

  function logic [15:0] some_base();
    return p_base[$urandom_range(0, n_parts - 1)][15:0];
  endfunction
endclass

// File: dv/tb_top.sv
// Top of the dynamic partition allocator testbench: clock, reset, drivers.
// Depends on dpa_pkg, alloc_scoreboard and dynamic_partition_allocator.
`timescale 1ns / 100ps
module tb_top;
  import dpa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_CMDS  = 78;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [16:0] in_request_size = '0;
  logic [15:0] in_free_base = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_granted_base;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;
  int          cycles = 0;
  int          n_cmds = 0;
  int          n_cfg = 0;
  alloc_scoreboard sb;

  always #5 clk = ~clk;

  dynamic_partition_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_request_size(in_request_size),
    .in_free_base(in_free_base), .out_valid(out_valid),
    .out_status(out_status), .out_granted_base(out_granted_base),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_status, out_granted_base);
    if (cycles > CYCLE_LIMIT) begin
      $display("** dynamic_partition_allocator: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] cmd, logic [16:0] req, logic [15:0] fb);
    start <= 1'b1;
    in_command <= cmd;
    in_request_size <= req;
    in_free_base <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, req, fb);
    n_cmds++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [16:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_cmd();
    int r;
    logic [16:0] sz;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) sz = 17'($urandom_range(0, 17'h1FFFF));
    else sz = 17'($urandom_range(1, 600));
    if (r < 55) send_cmd(CMD_ALLOC, sz, 16'($urandom));
    else if (r < 88) send_cmd(CMD_FREE, 17'($urandom),
                              ($urandom_range(0, 7) == 0) ? 16'($urandom) : sb.some_base());
    else if (r < 96) send_cmd(CMD_COMPACT, 17'($urandom), 16'($urandom));
    else send_cmd(CMD_UNUSED, 17'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_cmd(CMD_ALLOC, 17'd0, 16'hFFFF);
    send_cmd(CMD_ALLOC, 17'd100, 16'd0);
    send_cmd(CMD_ALLOC, 17'd5000, 16'd0);
    send_cmd(CMD_FREE, 17'h1FFFF, 16'd7);
    send_cmd(CMD_FREE, 17'd0, 16'd0);
    send_cmd(CMD_FREE, 17'd0, 16'd0);
    send_cmd(CMD_UNUSED, 17'h1FFFF, 16'hFFFF);
    send_cmd(CMD_ALLOC, 17'd4096, 16'd0);
    send_cmd(CMD_FREE, 17'd0, 16'd0);
    write_cfg(REG_MEMORY_SIZE, 17'd0);
    send_cmd(CMD_ALLOC, 17'd1, 16'd0);
    send_cmd(CMD_COMPACT, 17'd0, 16'd0);
    write_cfg(REG_MEMORY_SIZE, 17'h1FFFF);
    write_cfg(REG_FIT_MODE, 17'h1FFFF);
    for (int i = 0; i < 66; i++) send_cmd(CMD_ALLOC, 17'd1, 16'd0);
    send_cmd(CMD_ALLOC, 17'h10000, 16'd0);
    send_cmd(CMD_FREE, 17'd0, 16'd3);
    send_cmd(CMD_FREE, 17'd0, 16'd5);
    send_cmd(CMD_COMPACT, 17'd0, 16'd0);
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_FIT_MODE, 17'(ph % 2));
      case (ph)
        0: write_cfg(REG_MEMORY_SIZE, 17'd4096);
        1: write_cfg(REG_MEMORY_SIZE, 17'h10000);
        2: write_cfg(REG_MEMORY_SIZE, 17'd1);
        3: write_cfg(REG_MEMORY_SIZE, 17'd2000);
        default: write_cfg(REG_MEMORY_SIZE, 17'($urandom_range(1, 17'h1FFFF)));
      endcase
      for (int k = 0; k < PHASE_CMDS; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && k < PHASE_CMDS; b++, k++) rand_cmd();
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    drain();
    repeat (150) @(posedge clk);
    $display("Ran %0d commands across %0d register writes, %0d result beats checked.",
             n_cmds, n_cfg, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** dynamic_partition_allocator: PASSED **");
    else
      $display("** dynamic_partition_allocator: FAILED **");
    $finish;
  end
endmodule
